@@ rtl/core/sed_pkg.sv @@
// Types, codes, character constants and a hex digit decoder for the string escape decoder.
`default_nettype none

package sed_pkg;

    // Input item: one raw byte of an escaped string.
    typedef struct packed {
        logic [7:0] char_in;
        logic       string_end;
    } t_in_item;

    // Result item: one decoded byte or an error report.
    typedef struct packed {
        logic [7:0] char_out;
        logic [1:0] error_code;
        logic       run_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BS_END  = 2'd1,
        ERR_BAD_HEX = 2'd2,
        ERR_UNKNOWN = 2'd3
    } t_err;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_ESC    = 5'b00010,
        MODE_HEX1   = 5'b00100,
        MODE_HEX2   = 5'b01000,
        MODE_DROP   = 5'b10000
    } t_mode;

    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_DQUOTE    = 8'h22;
    localparam logic [7:0] C_SQUOTE    = 8'h27;
    localparam logic [7:0] C_LOWER_B   = 8'h62;
    localparam logic [7:0] C_LOWER_F   = 8'h66;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_R   = 8'h72;
    localparam logic [7:0] C_LOWER_T   = 8'h74;
    localparam logic [7:0] C_LOWER_V   = 8'h76;
    localparam logic [7:0] C_LOWER_X   = 8'h78;

    localparam logic [7:0] C_CTRL_BS  = 8'h08;
    localparam logic [7:0] C_CTRL_FF  = 8'h0C;
    localparam logic [7:0] C_CTRL_LF  = 8'h0A;
    localparam logic [7:0] C_CTRL_CR  = 8'h0D;
    localparam logic [7:0] C_CTRL_TAB = 8'h09;
    localparam logic [7:0] C_CTRL_VT  = 8'h0B;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'b0_0000;
            end
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sed_stream_if.sv @@
// Valid/ready stream channel carrying one item of a given type.
`default_nettype none

interface sed_stream_if #(
    parameter type t_item = logic
);
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/string_escape_decoder.sv @@
// Streaming decoder for backslash escapes in byte strings.
// Each item passes through the input register and then the result register before its result is valid.
// Throughput: one item per cycle; the input register, decode logic and
//   result register form a two-stage pipeline that stalls only on o_out.ready.
// Reset (synchronous, i_rst_n low): both stages empty, decode mode back to
//   plain text, stored high nibble cleared.
`default_nettype none

module string_escape_decoder (
    input  wire            i_clk,
    input  wire            i_rst_n,
    sed_stream_if.sink     i_in,
    sed_stream_if.source   o_out
);

    logic                 r_in_valid;
    sed_pkg::t_in_item    r_in;
    logic                 r_out_valid;
    sed_pkg::t_out_item   r_out;
    sed_pkg::t_mode       r_mode;
    logic [3:0]           r_nibble;

    sed_pkg::t_mode       n_mode;
    logic [3:0]           n_nibble;
    logic                 advance;
    logic                 in_ready;
    logic                 emit;
    logic [7:0]           ch;
    sed_pkg::t_err        err;
    logic [4:0]           hexv;

    assign advance  = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign hexv = sed_pkg::hex_digit(r_in.char_in);

    always_comb begin
        n_mode   = sed_pkg::MODE_NORMAL;
        n_nibble = r_nibble;
        ch       = 8'h00;
        err      = sed_pkg::ERR_NONE;
        emit     = 1'b1;
        case (r_mode)
            sed_pkg::MODE_ESC: begin
                case (r_in.char_in)
                    sed_pkg::C_LOWER_B:   ch = sed_pkg::C_CTRL_BS;
                    sed_pkg::C_LOWER_F:   ch = sed_pkg::C_CTRL_FF;
                    sed_pkg::C_LOWER_N:   ch = sed_pkg::C_CTRL_LF;
                    sed_pkg::C_LOWER_R:   ch = sed_pkg::C_CTRL_CR;
                    sed_pkg::C_LOWER_T:   ch = sed_pkg::C_CTRL_TAB;
                    sed_pkg::C_LOWER_V:   ch = sed_pkg::C_CTRL_VT;
                    sed_pkg::C_BACKSLASH: ch = sed_pkg::C_BACKSLASH;
                    sed_pkg::C_DQUOTE:    ch = sed_pkg::C_DQUOTE;
                    sed_pkg::C_SQUOTE:    ch = sed_pkg::C_SQUOTE;
                    sed_pkg::C_LOWER_X: begin
                        if (r_in.string_end) begin
                            err = sed_pkg::ERR_BAD_HEX;
                        end else begin
                            n_mode = sed_pkg::MODE_HEX1;
                            emit   = 1'b0;
                        end
                    end
                    default: err = sed_pkg::ERR_UNKNOWN;
                endcase
            end
            sed_pkg::MODE_HEX1: begin
                if (!hexv[4] || r_in.string_end) begin
                    err = sed_pkg::ERR_BAD_HEX;
                end else begin
                    n_nibble = hexv[3:0];
                    n_mode   = sed_pkg::MODE_HEX2;
                    emit     = 1'b0;
                end
            end
            sed_pkg::MODE_HEX2: begin
                if (!hexv[4]) begin
                    err = sed_pkg::ERR_BAD_HEX;
                end else begin
                    ch = {r_nibble, hexv[3:0]};
                end
            end
            sed_pkg::MODE_DROP: begin
                emit   = 1'b0;
                n_mode = sed_pkg::MODE_DROP;
            end
            default: begin
                if (r_in.char_in == sed_pkg::C_BACKSLASH) begin
                    if (r_in.string_end) begin
                        err = sed_pkg::ERR_BS_END;
                    end else begin
                        n_mode = sed_pkg::MODE_ESC;
                        emit   = 1'b0;
                    end
                end else begin
                    ch = r_in.char_in;
                end
            end
        endcase
        // an error ends the string's results; drop the rest of it
        if (err != sed_pkg::ERR_NONE) begin
            ch     = 8'h00;
            n_mode = sed_pkg::MODE_DROP;
        end
        if (r_in.string_end) begin
            n_mode = sed_pkg::MODE_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= sed_pkg::MODE_NORMAL;
            r_nibble    <= 4'h0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && emit;
                if (r_in_valid) begin
                    r_mode   <= n_mode;
                    r_nibble <= n_nibble;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.char_out   <= ch;
            r_out.error_code <= err;
            r_out.run_last   <= r_in.string_end || (err != sed_pkg::ERR_NONE);
        end
    end

    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("decode mode lost its one-hot code");

    a_end_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in.string_end) |=> (r_mode == sed_pkg::MODE_NORMAL))
        else $error("decode mode not back to plain text after a string end");

    a_drop_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_mode == sed_pkg::MODE_DROP) |=> !r_out_valid)
        else $error("result produced while dropping after an error");

    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != sed_pkg::ERR_NONE)
            |-> (r_out.run_last && r_out.char_out == 8'h00))
        else $error("error result does not close the string with a zero byte");

endmodule

`default_nettype wire

@@ test/string_escape_decoder_tb.sv @@
// Self-checking testbench for the string escape decoder: directed and random escaped strings against a predictor.
`default_nettype none

module string_escape_decoder_tb;
    import sed_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sed_stream_if #(.t_item(t_in_item))  in_if ();
    sed_stream_if #(.t_item(t_out_item)) out_if ();

    string_escape_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item    raw_q[$];
    t_out_item   decoded_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    // Predictor state
    t_mode      dec_mode = MODE_NORMAL;
    logic [3:0] hi_nib = 4'h0;

    // Long receiver hold-off, requested by the stimulus process
    int unsigned hold_req = 0;
    int unsigned hold_ack = 0;
    int unsigned hold_left = 0;
    logic        rx_hold;

    assign rx_hold = (hold_left != 0);

    function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = c[3:0];
            return 1'b1;
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_simple_esc(input logic [7:0] c);
        return c inside {C_LOWER_B, C_LOWER_F, C_LOWER_N, C_LOWER_R, C_LOWER_T, C_LOWER_V,
                         C_BACKSLASH, C_DQUOTE, C_SQUOTE};
    endfunction

    // Advance the decode state by one byte and queue the result it produces, if any.
    task automatic decode_byte(input t_in_item it);
        t_mode      nxt;
        t_err       err;
        logic [7:0] ch;
        logic [3:0] v;
        bit         is_hex;
        bit         emit;
        t_out_item  res;
        nxt = MODE_NORMAL;
        err = ERR_NONE;
        ch = it.char_in;
        emit = 1'b1;
        is_hex = hex_val(it.char_in, v);
        case (dec_mode)
            MODE_ESC: begin
                case (it.char_in)
                    C_LOWER_B: ch = C_CTRL_BS;
                    C_LOWER_F: ch = C_CTRL_FF;
                    C_LOWER_N: ch = C_CTRL_LF;
                    C_LOWER_R: ch = C_CTRL_CR;
                    C_LOWER_T: ch = C_CTRL_TAB;
                    C_LOWER_V: ch = C_CTRL_VT;
                    C_BACKSLASH, C_DQUOTE, C_SQUOTE: ch = it.char_in;
                    C_LOWER_X: begin
                        if (it.string_end) begin
                            err = ERR_BAD_HEX;
                        end else begin
                            nxt = MODE_HEX1;
                            emit = 1'b0;
                        end
                    end
                    default: err = ERR_UNKNOWN;
                endcase
            end
            MODE_HEX1: begin
                if (!is_hex || it.string_end) begin
                    err = ERR_BAD_HEX;
                end else begin
                    hi_nib = v;
                    nxt = MODE_HEX2;
                    emit = 1'b0;
                end
            end
            MODE_HEX2: begin
                if (!is_hex) err = ERR_BAD_HEX;
                else ch = {hi_nib, v};
            end
            MODE_DROP: begin
                nxt = MODE_DROP;
                emit = 1'b0;
            end
            default: begin
                if (it.char_in == C_BACKSLASH) begin
                    if (it.string_end) begin
                        err = ERR_BS_END;
                    end else begin
                        nxt = MODE_ESC;
                        emit = 1'b0;
                    end
                end
            end
        endcase
        if (err != ERR_NONE) begin
            ch = 8'h00;
            nxt = MODE_DROP;
        end
        if (it.string_end) nxt = MODE_NORMAL;
        dec_mode = nxt;
        if (emit) begin
            res.char_out = ch;
            res.error_code = err;
            res.run_last = it.string_end || (err != ERR_NONE);
            decoded_q.push_back(res);
        end
    endtask

    // Sender: offer the head of raw_q, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) decode_byte(raw_q.pop_front());
            if (in_if.valid && !in_if.ready) begin
                // hold the offered item
            end else if (raw_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_if.valid <= 1'b1;
                in_if.data <= raw_q[0];
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_res;
        t_out_item act_res;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                act_res = out_if.data;
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: char_out %02h error_code %0d run_last %0b",
                           act_res.char_out, act_res.error_code, act_res.run_last);
                    mismatch_cnt++;
                end else begin
                    exp_res = decoded_q.pop_front();
                    if (act_res.char_out !== exp_res.char_out) begin
                        $error("char_out: expected %02h, got %02h",
                               exp_res.char_out, act_res.char_out);
                        mismatch_cnt++;
                    end
                    if (act_res.error_code !== exp_res.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               exp_res.error_code, act_res.error_code);
                        mismatch_cnt++;
                    end
                    if (act_res.run_last !== exp_res.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               exp_res.run_last, act_res.run_last);
                        mismatch_cnt++;
                    end
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] c, input bit last);
        t_in_item it;
        it.char_in = c;
        it.string_end = last;
        raw_q.push_back(it);
    endtask

    // Push a literal string, flagging its last byte as the string end.
    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned d;
        d = $urandom_range(15);
        if (d < 10) return 8'(d) + "0";
        return 8'(d - 10) + ($urandom_range(1) ? "a" : "A");
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(255)); while (hex_val(c, v));
        return c;
    endfunction

    function automatic logic [7:0] rand_unknown_esc();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_simple_esc(c) || c == C_LOWER_X);
        return c;
    endfunction

    task automatic push_token(input bit last);
        logic [7:0] esc_set[9] = '{C_LOWER_B, C_LOWER_F, C_LOWER_N, C_LOWER_R, C_LOWER_T,
                                   C_LOWER_V, C_BACKSLASH, C_DQUOTE, C_SQUOTE};
        logic [7:0] c;
        int unsigned kind;
        kind = $urandom_range(3);
        if (kind < 2) begin
            do c = 8'($urandom_range(255)); while (c == C_BACKSLASH);
            push_byte(c, last);
        end else if (kind == 2) begin
            push_byte(C_BACKSLASH, 1'b0);
            push_byte(esc_set[$urandom_range(8)], last);
        end else begin
            push_byte(C_BACKSLASH, 1'b0);
            push_byte(C_LOWER_X, 1'b0);
            push_byte(rand_hex_char(), 1'b0);
            push_byte(rand_hex_char(), last);
        end
    endtask

    task automatic push_tail(input bit tail);
        int unsigned n;
        if (!tail) return;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(255)), i == n - 1);
    endtask

    // Broken string: a well-formed prefix, then one of the error cases.
    task automatic push_broken();
        int unsigned n;
        bit          tail;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) push_token(1'b0);
        tail = $urandom_range(1);
        push_byte(C_BACKSLASH, 1'b0);
        case ($urandom_range(4))
            0: begin
                raw_q[raw_q.size() - 1].string_end = 1'b1;
            end
            1: push_byte(C_LOWER_X, 1'b1);
            2: begin
                push_byte(C_LOWER_X, 1'b0);
                push_byte(rand_hex_char(), 1'b1);
            end
            3: begin
                push_byte(C_LOWER_X, 1'b0);
                push_byte(rand_non_hex(), !tail);
                push_tail(tail);
            end
            default: begin
                push_byte(rand_unknown_esc(), !tail);
                push_tail(tail);
            end
        endcase
    endtask

    task automatic push_noise();
        int unsigned n;
        logic [7:0]  c;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(99) < 30) ? C_BACKSLASH : 8'($urandom_range(255));
            push_byte(c, (i == n - 1) || ($urandom_range(99) < 20));
        end
    endtask

    task automatic push_random(input int unsigned n_items);
        int unsigned goal;
        int unsigned kind;
        int unsigned n;
        goal = raw_q.size() + n_items;
        while (raw_q.size() < goal) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) push_token(i == n - 1);
            end else if (kind < 85) begin
                push_broken();
            end else begin
                push_noise();
            end
        end
    endtask

    // Wait until every item is taken and every result is back.
    task automatic drain();
        while (raw_q.size() != 0 || decoded_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every simple escape in one string
        push_str("\\b\\f\\n\\r\\t\\v\\\\\\\"\\'");
        // Byte extremes as plain text, then a mixed-case hex escape
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_str("\\xaF");
        // Backslash as last byte, hex escape cut short twice
        push_str("\\");
        push_str("\\x");
        push_str("\\x7");
        // High byte after \x is not a digit; the rest of the string is dropped
        push_byte(C_BACKSLASH, 1'b0);
        push_byte(C_LOWER_X, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_str("\\q");

        push_random(420);
        hold_req++;
        drain();

        tx_idle_pct = 79;
        rx_stall_pct = 0;
        push_random(470);
        drain();

        tx_idle_pct = 0;
        rx_stall_pct = 79;
        push_random(470);
        drain();

        tx_idle_pct = 26;
        rx_stall_pct = 26;
        push_random(470);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
